>>> rtl/mst_pkg.sv
// shared constants and types for the spanning tree block
`timescale 1ns / 1ps
package mst_pkg;
    localparam int MaxVerticesDef = 32;
    localparam int MaxEdgesDef    = 256;
    localparam int WeightW        = 16;
    localparam int VertexW        = 5;
    localparam int TotalW         = 22;
    localparam int KeyW           = WeightW + 2 * VertexW;

    typedef logic [KeyW-1:0] key_t;
endpackage

>>> rtl/mst_edge_ram.sv
// edge store memory, one write and one registered read port
`timescale 1ns / 1ps
module mst_edge_ram #(
    parameter int Depth = 256,
    parameter int AddrW = 8
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  mst_pkg::key_t    wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output mst_pkg::key_t    rd_data
);
    import mst_pkg::*;

    key_t mem [Depth];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> rtl/mst_parent_ram.sv
// union-find parent table, one write and one registered read port
`timescale 1ns / 1ps
module mst_parent_ram #(
    parameter int Depth = 32,
    parameter int AddrW = 5
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [AddrW-1:0] wr_data,
    input  logic [AddrW-1:0] rd_addr,
    output logic [AddrW-1:0] rd_data
);
    logic [AddrW-1:0] mem [Depth];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> rtl/min_spanning_tree_kruskal_top.sv
// kruskal spanning forest: edge loading, insertion sort, union-find walk
// loading takes one edge per cycle; after the last edge the run sorts the edges by
//   insertion sort (compare and shift per entry), then resets the parent table
//   and walks each edge through the union-find search, joining distinct roots
// throughput: sequential, one graph at a time; ready stays low during a run
// reset: rst_n asynchronous, active low; clears the sequencer, counts and flags
`timescale 1ns / 1ps
module min_spanning_tree_kruskal_top #(
    parameter int MAX_VERTICES = mst_pkg::MaxVerticesDef,
    parameter int MAX_EDGES    = mst_pkg::MaxEdgesDef
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [mst_pkg::WeightW-1:0] weight_in,
    input  logic [mst_pkg::VertexW-1:0]       vertex_a_in,
    input  logic [mst_pkg::VertexW-1:0]       vertex_b_in,
    input  logic                              last_edge,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [mst_pkg::VertexW-1:0]       mst_vertex_a,
    output logic [mst_pkg::VertexW-1:0]       mst_vertex_b,
    output logic signed [mst_pkg::WeightW-1:0] mst_edge_weight,
    output logic                              is_total,
    output logic signed [mst_pkg::TotalW-1:0] total_weight,
    output logic                              edges_dropped,
    output logic                              last_result
);
    import mst_pkg::*;

    localparam int EA = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int VA = $clog2(MAX_VERTICES);
    localparam int GW = VA + 1;

    typedef enum logic [4:0] {
        S_LOAD, S_SI, S_SJR, S_SJW, S_SCMP, S_SPUT,
        S_PINIT, S_WRD, S_WWAIT, S_WCHK,
        S_FA, S_FAW, S_FGP, S_FGPW, S_FB,
        S_JOIN, S_OUT, S_TOT
    } state_t;

    state_t state_reg;
    logic [CW-1:0] count_reg, i_reg, j_reg;
    key_t key_reg, cur_reg;
    logic ovf_reg;
    logic signed [TotalW-1:0] sum_reg;
    logic [VA-1:0] v_reg, ra_reg;
    logic [GW-1:0] guard_reg;
    logic side_reg;
    logic [VA:0] init_reg;
    logic [5:0] nout_reg;

    // memory port signals
    logic e_we;
    logic [EA-1:0] e_wa, e_ra;
    key_t e_wd, e_rd;
    logic p_we;
    logic [VA-1:0] p_wa, p_wd, p_ra, p_rd;

    mst_edge_ram #(.Depth(MAX_EDGES), .AddrW(EA)) u_edges (
        .clk(clk), .wr_en(e_we), .wr_addr(e_wa), .wr_data(e_wd),
        .rd_addr(e_ra), .rd_data(e_rd));
    mst_parent_ram #(.Depth(MAX_VERTICES), .AddrW(VA)) u_parent (
        .clk(clk), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
        .rd_addr(p_ra), .rd_data(p_rd));

    assign in_ready = (state_reg == S_LOAD);

    logic in_fire;
    assign in_fire = in_valid && in_ready;

    key_t in_key;
    assign in_key = {~weight_in[WeightW-1], weight_in[WeightW-2:0], vertex_a_in, vertex_b_in};

    // vertex fields of current edge and range check
    logic [VertexW-1:0] cur_a, cur_b;
    assign cur_a = cur_reg[2*VertexW-1:VertexW];
    assign cur_b = cur_reg[VertexW-1:0];
    logic a_ok, b_ok;
    assign a_ok = (32'(cur_a) < 32'(MAX_VERTICES));
    assign b_ok = (32'(cur_b) < 32'(MAX_VERTICES));

    // memory control
    always_comb
    begin
        e_we = 1'b0;
        e_wa = i_reg[EA-1:0];
        e_wd = in_key;
        e_ra = i_reg[EA-1:0];
        p_we = 1'b0;
        p_wa = init_reg[VA-1:0];
        p_wd = init_reg[VA-1:0];
        p_ra = v_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                e_we = in_fire && (count_reg < CW'(MAX_EDGES));
                e_wa = count_reg[EA-1:0];
            end
            S_SJR:   e_ra = j_reg[EA-1:0] - EA'(1);
            S_SJW:
            begin
                // shift entry j-1 up and fetch the one below it
                e_we = 1'b1;
                e_wa = j_reg[EA-1:0];
                e_wd = e_rd;
                e_ra = j_reg[EA-1:0] - EA'(2);
            end
            S_SCMP:  e_ra = j_reg[EA-1:0] - EA'(1);
            S_SPUT:
            begin
                e_we = 1'b1;
                e_wa = j_reg[EA-1:0];
                e_wd = key_reg;
            end
            S_PINIT: p_we = 1'b1;
            S_FGP:   p_ra = p_rd;
            S_FGPW:
            begin
                p_we = 1'b1;
                p_wa = v_reg;
                p_wd = p_rd;
                p_ra = p_rd;
            end
            S_JOIN:
            begin
                p_we = 1'b1;
                p_wa = ra_reg;
                p_wd = v_reg;
            end
            default: ;
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            sum_reg   <= '0;
            out_valid <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            nout_reg  <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (count_reg < CW'(MAX_EDGES))
                            count_reg <= count_reg + CW'(1);
                        else
                            ovf_reg <= 1'b1;
                        if (last_edge)
                        begin
                            i_reg     <= CW'(1);
                            state_reg <= S_SI;
                        end
                    end
                end
                // insertion sort: key at i, shift larger ones up
                S_SI:
                begin
                    if (i_reg >= count_reg)
                    begin
                        init_reg  <= '0;
                        state_reg <= S_PINIT;
                    end
                    else
                    begin
                        j_reg     <= i_reg;
                        state_reg <= S_SJR;
                    end
                end
                S_SJR:
                begin
                    // e_rd holds entry i now, read of j-1 issued
                    key_reg   <= e_rd;
                    state_reg <= S_SCMP;
                end
                S_SCMP:
                begin
                    if (e_rd > key_reg)
                        state_reg <= S_SJW;
                    else
                        state_reg <= S_SPUT;
                end
                S_SJW:
                begin
                    j_reg <= j_reg - CW'(1);
                    if (j_reg == CW'(1))
                        state_reg <= S_SPUT;
                    else
                        state_reg <= S_SCMP;
                end
                S_SPUT:
                begin
                    i_reg     <= i_reg + CW'(1);
                    state_reg <= S_SI;
                end
                S_PINIT:
                begin
                    init_reg <= init_reg + (VA+1)'(1);
                    if (init_reg == (VA+1)'(MAX_VERTICES - 1))
                    begin
                        i_reg     <= '0;
                        sum_reg   <= '0;
                        nout_reg  <= '0;
                        state_reg <= S_WRD;
                    end
                end
                // edge walk
                S_WRD:
                begin
                    if (i_reg >= count_reg)
                        state_reg <= S_TOT;
                    else
                        state_reg <= S_WWAIT;
                end
                S_WWAIT:
                begin
                    cur_reg   <= e_rd;
                    state_reg <= S_WCHK;
                end
                S_WCHK:
                begin
                    if (!a_ok || !b_ok)
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_WRD;
                    end
                    else
                    begin
                        v_reg     <= VA'(cur_a);
                        side_reg  <= 1'b0;
                        guard_reg <= '0;
                        state_reg <= S_FA;
                    end
                end
                // p_rd = parent[v]
                S_FA:    state_reg <= S_FAW;
                S_FAW:
                begin
                    if (p_rd == v_reg || guard_reg >= GW'(MAX_VERTICES))
                        state_reg <= S_FB;
                    else
                        state_reg <= S_FGP;
                end
                S_FGP:   state_reg <= S_FGPW;
                S_FGPW:
                begin
                    // p_rd = grandparent, written to parent[v]
                    v_reg     <= p_rd;
                    guard_reg <= guard_reg + GW'(1);
                    state_reg <= S_FA;
                end
                S_FB:
                begin
                    if (!side_reg)
                    begin
                        ra_reg    <= v_reg;
                        v_reg     <= VA'(cur_b);
                        side_reg  <= 1'b1;
                        guard_reg <= '0;
                        state_reg <= S_FA;
                    end
                    else if (ra_reg == v_reg)
                    begin
                        i_reg     <= i_reg + CW'(1);
                        state_reg <= S_WRD;
                    end
                    else
                        state_reg <= S_JOIN;
                end
                S_JOIN:
                begin
                    sum_reg <= sum_reg + TotalW'($signed(
                        {~cur_reg[KeyW-1], cur_reg[KeyW-2:2*VertexW]}));
                    i_reg <= i_reg + CW'(1);
                    if (nout_reg < 6'd31)
                    begin
                        nout_reg        <= nout_reg + 6'd1;
                        mst_vertex_a    <= cur_a;
                        mst_vertex_b    <= cur_b;
                        mst_edge_weight <= {~cur_reg[KeyW-1], cur_reg[KeyW-2:2*VertexW]};
                        is_total        <= 1'b0;
                        total_weight    <= '0;
                        edges_dropped   <= 1'b0;
                        last_result     <= 1'b0;
                        out_valid       <= 1'b1;
                        state_reg       <= S_OUT;
                    end
                    else
                        state_reg <= S_WRD;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        state_reg <= last_result ? S_LOAD : S_WRD;
                    end
                end
                S_TOT:
                begin
                    mst_vertex_a    <= '0;
                    mst_vertex_b    <= '0;
                    mst_edge_weight <= '0;
                    is_total        <= 1'b1;
                    total_weight    <= sum_reg;
                    edges_dropped   <= ovf_reg;
                    last_result     <= 1'b1;
                    out_valid       <= 1'b1;
                    count_reg       <= '0;
                    ovf_reg         <= 1'b0;
                    sum_reg         <= '0;
                    state_reg       <= S_OUT;
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end
endmodule
